FILE: hw/rtl/segmented_prime_sieve_top_defines.svh
// Assertion macros shared by the sieve checker.
`ifndef SEGMENTED_PRIME_SIEVE_TOP_DEFINES_SVH
`define SEGMENTED_PRIME_SIEVE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sps_pkg.sv
// Types and constants shared by the segmented prime sieve.
package sps_pkg;

	localparam int SEG_DEPTH = 4096;
	localparam int SEG_AW    = $clog2(SEG_DEPTH);

	localparam int BASE_W     = 24;
	localparam int SIZE_W     = 13;
	localparam int PRIME_W    = 16;
	localparam int INDEX_W    = 12;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam int OFF_W      = 17;
	localparam int SQ_W       = 2 * PRIME_W;
	localparam int RCNT_W     = $clog2(BASE_W);

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

	localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b1;

	localparam logic [KIND_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] REQ_CROSS = 2'd1;
	localparam logic [KIND_W-1:0] REQ_QUERY = 2'd2;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_MUL,
		ST_DIV,
		ST_OFFS,
		ST_CHK,
		ST_MARK,
		ST_QRD,
		ST_RESP
	} sps_state_t;

endpackage

FILE: hw/rtl/sps_ifs.sv
// Request and response channel interfaces of the segmented prime sieve.
interface sps_req_if import sps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  req_type;
	logic [PRIME_W-1:0] prime_value;
	logic [INDEX_W-1:0] query_index;

	modport source (output valid, req_type, prime_value, query_index, input ready);
	modport sink (input valid, req_type, prime_value, query_index, output ready);
endinterface

interface sps_rsp_if import sps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] done_kind;
	logic              is_composite;

	modport source (output valid, done_kind, is_composite, input ready);
	modport sink (input valid, done_kind, is_composite, output ready);
endinterface

FILE: hw/rtl/sps_rem_unit.sv
// Bit-serial restoring remainder unit: segment base modulo the sieving prime.
module sps_rem_unit import sps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [BASE_W-1:0]  dividend,
	input  logic [PRIME_W-1:0] divisor,
	output logic               done,
	output logic [PRIME_W-1:0] remainder
);

	logic [PRIME_W-1:0] rem_q;
	logic [BASE_W-1:0]  dvd_q;
	logic [RCNT_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [PRIME_W:0]   trial;
	logic [PRIME_W:0]   dsr_ext;
	logic [PRIME_W-1:0] rem_next;

	assign trial   = {rem_q, dvd_q[BASE_W-1]};
	assign dsr_ext = {1'b0, divisor};

	// The partial remainder stays below the divisor, so one subtract per bit is enough.
	always_comb begin
		if (trial >= dsr_ext) begin
			rem_next = PRIME_W'(trial - dsr_ext);
		end else begin
			rem_next = PRIME_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == RCNT_W'(BASE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[BASE_W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

FILE: hw/rtl/sps_flag_mem.sv
// One-bit-wide flag memory with one write port and one registered read port.
module sps_flag_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/segmented_prime_sieve_top.sv
// Top level of the segmented prime sieve: sequencer, registers and unit hookup.
// The block holds one composite flag per entry of a segment that starts at segment_base.
// Requests arrive on the req channel and every request returns one transaction on rsp.
// A clear request zeroes all SEG_DEPTH flags, one entry per cycle.
// A cross request squares the prime, runs a bit-serial base-mod-prime remainder,
// forms the first offset, then marks one flag per cycle up to the end of the segment.
// A query request reads one flag from the memory read port and answers with it.
// A prime below 2 or an unused request type answers without touching flags.
// The single memory write port and the serial remainder unit set the pace of these requests.
// req.ready is high only while the sequencer is idle; one request is in flight at a time.
// Results sit in an output register, so a stalled receiver does not block the next
// request; a finished request waits only if the previous result has not yet been taken.
// After reset the block sweeps all SEG_DEPTH flags to zero and holds
// req.ready low meanwhile; configuration writes are taken at any time but must only be
// issued while no request is in flight.
module segmented_prime_sieve_top import sps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	sps_req_if.sink               req,
	sps_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	sps_state_t state_q, state_d;

	// Configuration registers.
	logic [BASE_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;

	// Request payload captured at acceptance.
	logic [KIND_W-1:0]  kind_q;
	logic [PRIME_W-1:0] prime_q;
	logic               qok_q;

	// Cross datapath.
	logic [SQ_W-1:0]    sq_q;
	logic [SQ_W-1:0]    off32_q;
	logic [OFF_W-1:0]   off_q;
	logic [SEG_AW-1:0]  cnt_q;
	logic               mark_q;

	// Output register.
	logic               rsp_valid_q;
	logic [KIND_W-1:0]  rsp_kind_q;
	logic               rsp_mark_q;

	// Sequencer outputs.
	logic               accept;
	logic               rem_start;
	logic               rem_done;
	logic [PRIME_W-1:0] rem_val;
	logic               mem_we;
	logic [SEG_AW-1:0]  mem_waddr;
	logic               mem_wdata;
	logic               mem_rdata;
	logic               rsp_load;
	logic               sweep_last;

	logic [OFF_W-1:0]   seg_len;
	logic [SQ_W-1:0]    base_ext;
	logic [SQ_W-1:0]    wrap_off;
	logic [OFF_W-1:0]   off_next;
	logic               mark_last;
	logic               in_window;

	assign accept = req.valid && req.ready;

	// Entries in use: segment_size, limited to the store depth.
	assign seg_len = (32'(size_q) > SEG_DEPTH) ? OFF_W'(SEG_DEPTH) : OFF_W'(size_q);

	assign base_ext = SQ_W'(base_q);

	// First multiple of the prime at or past the base when the square lies below it.
	assign wrap_off = (rem_val == '0) ? '0 : SQ_W'(prime_q - rem_val);

	assign in_window  = (off32_q < SQ_W'(seg_len));
	assign off_next   = off_q + OFF_W'(prime_q);
	assign mark_last  = (off_next >= seg_len);
	assign sweep_last = (cnt_q == SEG_AW'(SEG_DEPTH - 1));

	// The output slot is free when empty or when its transaction completes this cycle.
	assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rem_start = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.req_type == REQ_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (req.req_type == REQ_CROSS) begin
						state_d = (req.prime_value < PRIME_W'(2)) ? ST_RESP : ST_MUL;
					end else if (req.req_type == REQ_QUERY) begin
						state_d = ST_QRD;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_last) begin
					state_d = ST_RESP;
				end
			end
			ST_MUL: begin
				rem_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (rem_done) begin
					state_d = ST_OFFS;
				end
			end
			ST_OFFS: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				state_d = in_window ? ST_MARK : ST_RESP;
			end
			ST_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = off_q[SEG_AW-1:0];
				mem_wdata = 1'b1;
				if (mark_last) begin
					state_d = ST_RESP;
				end
			end
			ST_QRD: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration writes; the sequencer only reads these while a request is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE: base_q <= cfg_wdata[BASE_W-1:0];
				CFG_SIZE: size_q <= cfg_wdata[SIZE_W-1:0];
				default:  base_q <= base_q;
			endcase
		end
	end

	// Sweep counter for the reset and clear passes; it wraps back to zero at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			cnt_q <= sweep_last ? '0 : cnt_q + 1'b1;
		end
	end

	// Request and cross datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.req_type;
			prime_q <= req.prime_value;
			qok_q   <= (32'(req.query_index) < SEG_DEPTH);
			mark_q  <= 1'b0;
		end
		if (state_q == ST_MUL) begin
			sq_q <= SQ_W'(prime_q) * SQ_W'(prime_q);
		end
		if (state_q == ST_OFFS) begin
			off32_q <= (sq_q >= base_ext) ? (sq_q - base_ext) : wrap_off;
		end
		if (state_q == ST_CHK) begin
			off_q <= off32_q[OFF_W-1:0];
		end else if (state_q == ST_MARK) begin
			off_q <= off_next;
		end
		if (state_q == ST_QRD) begin
			mark_q <= qok_q & mem_rdata;
		end
	end

	// Output register: filled by the sequencer, emptied by the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_kind_q <= kind_q;
			rsp_mark_q <= mark_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.done_kind    = rsp_kind_q;
	assign rsp.is_composite = rsp_mark_q;

	sps_rem_unit u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (base_q),
		.divisor   (prime_q),
		.done      (rem_done),
		.remainder (rem_val)
	);

	// The query index is read straight off the channel in the cycle it is accepted.
	sps_flag_mem #(
		.DEPTH (SEG_DEPTH)
	) u_flags (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (SEG_AW'(req.query_index)),
		.rdata (mem_rdata)
	);

endmodule

FILE: hw/rtl/sps_checker.sv
// Port-level checker for the segmented prime sieve and its bind to the top level.
`include "segmented_prime_sieve_top_defines.svh"

module sps_checker import sps_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [KIND_W-1:0] rsp_done_kind,
	input logic              rsp_is_composite
);

	// A stalled result holds its payload.
	`SPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_done_kind) && $stable(rsp_is_composite), "sps: stalled result changed")

	// Only a query can report a composite mark.
	`SPS_ASSERT_NOW(a_mark_query_only, rsp_valid && rsp_done_kind != REQ_QUERY, !rsp_is_composite, "sps: composite mark on a non-query result")

	// Ready is low in the cycle after a request is accepted.
	`SPS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "sps: ready right after an accepted request")

endmodule

bind segmented_prime_sieve_top sps_checker u_sps_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_done_kind    (rsp.done_kind),
	.rsp_is_composite (rsp.is_composite)
);
